@@ rtl/bmsi_pkg.sv @@
// shared types and constants for the bank mapper with scanline irq
package bmsi_pkg;

  // field widths
  localparam int AddrW     = 16;
  localparam int DataW     = 8;
  localparam int OffsetW   = 21;
  localparam int BankCntW  = 7;
  localparam int BankW     = 8;
  localparam int NumBanks  = 8;
  localparam int BankIdxW  = $clog2(NumBanks);
  localparam int InDataW   = 24;
  localparam int OutDataW  = 32;

  // reset value of the program bank count
  localparam logic [BankCntW-1:0] PrgBankCntReset = 7'd4;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_READ  = 2'd1,
    OP_PPU_READ  = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  // register slot decode from cpu address bits 14..13
  typedef enum logic [1:0] {
    SLOT_BANK   = 2'd0,
    SLOT_MIRROR = 2'd1,
    SLOT_IRQ    = 2'd2,
    SLOT_ENABLE = 2'd3
  } slot_t;

  typedef logic [NumBanks-1:0][BankW-1:0] bank_file_t;

  // translation result handed back to the top level
  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic               cpu_low;
  } xlate_t;

endpackage

@@ rtl/bmsi_xlate.sv @@
// address translation for program and pattern reads
module bmsi_xlate
  import bmsi_pkg::*;
(
  input  op_t                 op,
  input  logic [AddrW-1:0]    address,
  input  logic [BankW-1:0]    bank_select,
  input  bank_file_t          bank_regs,
  input  logic [BankCntW-1:0] prg_bank_count,
  output xlate_t              result
);

  logic [BankCntW-1:0] n_eff;
  logic [BankW-1:0]    n_m1;
  logic [BankW-1:0]    n_m2;
  logic [BankW-1:0]    prg_bank;
  logic [OffsetW-1:0]  prg_off;
  logic [12:0]         chr_a;
  logic [BankW-1:0]    chr_bank;
  logic [17:0]         chr_off;
  logic                mode1;

  // fixed banks from the bank count, clamped to at least two
  assign n_eff = (prg_bank_count < BankCntW'(2)) ? BankCntW'(2) : prg_bank_count;
  assign n_m1  = BankW'(n_eff) - BankW'(1);
  assign n_m2  = BankW'(n_eff) - BankW'(2);
  assign mode1 = bank_select[6];

  // program bank per 8k slot
  always_comb begin
    unique case (slot_t'(address[14:13]))
      SLOT_BANK:   prg_bank = mode1 ? n_m2 : bank_regs[6];
      SLOT_MIRROR: prg_bank = bank_regs[7];
      SLOT_IRQ:    prg_bank = mode1 ? bank_regs[6] : n_m2;
      default:     prg_bank = n_m1;
    endcase
  end

  assign prg_off = {prg_bank, address[12:0]};

  // pattern space, halves swapped by bank select bit 7
  assign chr_a = address[12:0] ^ {bank_select[7], 12'd0};

  always_comb begin
    if (!chr_a[12]) begin
      chr_bank = bank_regs[BankIdxW'(chr_a[11])];
      chr_off  = {chr_bank[7:1], chr_a[10:0]};
    end else begin
      chr_bank = bank_regs[BankIdxW'(3'd2 + {1'b0, chr_a[11:10]})];
      chr_off  = {chr_bank, chr_a[9:0]};
    end
  end

  // select by operation
  always_comb begin
    result.cpu_low = 1'b0;
    result.offset  = '0;
    unique case (op)
      OP_CPU_WRITE: result.cpu_low = ~address[15];
      OP_CPU_READ: begin
        result.cpu_low = ~address[15];
        result.offset  = address[15] ? prg_off : '0;
      end
      OP_PPU_READ:  result.offset = OffsetW'(chr_off);
      default:      result.offset = '0;
    endcase
  end

endmodule

@@ rtl/bank_mapper_with_scanline_irq.sv @@
// top level of the bank mapper with scanline irq counter
//
// usage: each input word is one bus event. in_tuser carries the operation
// (cpu write, cpu read, ppu pattern read, scanline tick) and in_tdata the
// address and write byte. every input word yields exactly one output word
// with the translated rom offset, the mirroring and ram control bits, the
// irq request and an error status for cpu accesses below 0x8000.
// cfg_wr_en / cfg_wr_data set the number of 8k program banks present; the
// user must write it only while the block is idle; the block does not enforce this.
// each accepted input word is captured in the input register, then its result
// in the result register. throughput: one word per clock while the receiver does
// not stall, set by the single pass of translate and state update between the two registers.
// reset (rst_n low, synchronous) clears all mapper registers, sets the
// bank count to 4 and empties both stages.
// when the receiver stalls, the result stays in the output register, one
// more word is held in the input register, and then in_tready drops.
module bank_mapper_with_scanline_irq
  import bmsi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // address[15:0], write_data[23:16]
  input  logic [1:0]          in_tuser,   // operation[1:0]
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // rom_offset[20:0], mirror_select[21],
                                          // ram_enable[22], ram_write_protect[23],
                                          // irq_request[24], status[25], zero[31:26]
  // configuration
  input  logic                cfg_wr_en,
  input  logic [BankCntW-1:0] cfg_wr_data
);

  // input stage
  logic               in_valid_r;
  logic [1:0]         in_op_r;
  logic [AddrW-1:0]   in_addr_r;
  logic [DataW-1:0]   in_data_r;

  // mapper state
  logic [BankCntW-1:0] prg_cnt_r;
  logic [BankW-1:0]    bank_sel_r, bank_sel_nxt;
  bank_file_t          bank_regs_r, bank_regs_nxt;
  logic                mirror_r, mirror_nxt;
  logic                ram_en_r, ram_en_nxt;
  logic                ram_prot_r, ram_prot_nxt;
  logic [7:0]          irq_latch_r, irq_latch_nxt;
  logic [7:0]          irq_count_r, irq_count_nxt;
  logic                reload_r, reload_nxt;
  logic                irq_en_r, irq_en_nxt;
  logic                irq_pend_r, irq_pend_nxt;
  logic                irq_req;

  // output stage
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic   advance;
  op_t    op;
  xlate_t xl;

  assign op        = op_t'(in_op_r);
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  bmsi_xlate u_xlate (
    .op             (op),
    .address        (in_addr_r),
    .bank_select    (bank_sel_r),
    .bank_regs      (bank_regs_r),
    .prg_bank_count (prg_cnt_r),
    .result         (xl)
  );

  // register writes and scanline counter
  always_comb begin
    bank_sel_nxt  = bank_sel_r;
    bank_regs_nxt = bank_regs_r;
    mirror_nxt    = mirror_r;
    ram_en_nxt    = ram_en_r;
    ram_prot_nxt  = ram_prot_r;
    irq_latch_nxt = irq_latch_r;
    irq_count_nxt = irq_count_r;
    reload_nxt    = reload_r;
    irq_en_nxt    = irq_en_r;
    irq_pend_nxt  = irq_pend_r;
    irq_req       = 1'b0;
    if (op == OP_CPU_WRITE && !xl.cpu_low) begin
      unique case (slot_t'(in_addr_r[14:13]))
        SLOT_BANK: begin
          if (in_addr_r[0]) bank_regs_nxt[bank_sel_r[BankIdxW-1:0]] = in_data_r;
          else bank_sel_nxt = in_data_r;
        end
        SLOT_MIRROR: begin
          if (in_addr_r[0]) begin
            ram_prot_nxt = in_data_r[7];
            ram_en_nxt   = in_data_r[6];
          end else begin
            mirror_nxt = ~in_data_r[0];
          end
        end
        SLOT_IRQ: begin
          if (in_addr_r[0]) begin
            irq_count_nxt = '0;
            reload_nxt    = 1'b1;
          end else begin
            irq_latch_nxt = in_data_r;
          end
        end
        default: begin
          if (in_addr_r[0]) begin
            irq_en_nxt = 1'b1;
          end else begin
            irq_en_nxt   = 1'b0;
            irq_pend_nxt = 1'b0;
          end
        end
      endcase
    end else if (op == OP_TICK) begin
      if (irq_count_r == 8'd0 || reload_r) begin
        irq_count_nxt = irq_latch_r;
        reload_nxt    = 1'b0;
      end else begin
        irq_count_nxt = irq_count_r - 8'd1;
      end
      if (irq_count_nxt == 8'd0) irq_pend_nxt = 1'b1;
      irq_req = irq_en_r && irq_pend_nxt;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prg_cnt_r   <= PrgBankCntReset;
      bank_sel_r  <= '0;
      bank_regs_r <= '0;
      mirror_r    <= 1'b0;
      ram_en_r    <= 1'b0;
      ram_prot_r  <= 1'b0;
      irq_latch_r <= '0;
      irq_count_r <= '0;
      reload_r    <= 1'b0;
      irq_en_r    <= 1'b0;
      irq_pend_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) prg_cnt_r <= cfg_wr_data;
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        bank_sel_r  <= bank_sel_nxt;
        bank_regs_r <= bank_regs_nxt;
        mirror_r    <= mirror_nxt;
        ram_en_r    <= ram_en_nxt;
        ram_prot_r  <= ram_prot_nxt;
        irq_latch_r <= irq_latch_nxt;
        irq_count_r <= irq_count_nxt;
        reload_r    <= reload_nxt;
        irq_en_r    <= irq_en_nxt;
        irq_pend_r  <= irq_pend_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_addr_r <= in_tdata[15:0];
      in_data_r <= in_tdata[23:16];
    end
    if (advance) begin
      out_data_r <= {6'd0, xl.cpu_low, irq_req, ram_prot_nxt, ram_en_nxt,
                     mirror_nxt, xl.offset};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
